/* rtl/cstd_pkg.sv */
// cstd_pkg: shared types, register codes and status codes for the crank/sync decoder
// no dependencies; imported by crank_sync_trigger_decoder_core
`default_nettype none

package cstd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RegW    = 16;
  localparam int unsigned TimeW   = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CRANK_FILTER  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FILTER   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CRANKING_CYC  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_TIMEOUT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CRANK_TIMEOUT = 3'd4;

  // configuration reset values
  localparam logic [RegW-1:0] CRANK_FILTER_RST  = 16'd40;
  localparam logic [RegW-1:0] SYNC_FILTER_RST   = 16'd40;
  localparam logic [RegW-1:0] CRANKING_CYC_RST  = 16'd8;
  localparam logic [RegW-1:0] SYNC_TIMEOUT_RST  = 16'd1000;
  localparam logic [RegW-1:0] CRANK_TIMEOUT_RST = 16'd1000;

  // tooth index at which a sync edge is skipped
  localparam logic [RegW-1:0] SKIP_TOOTH = 16'd2;

  // request codes
  localparam logic [1:0] REQ_CRANK = 2'd0;
  localparam logic [1:0] REQ_SYNC  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // status codes
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_NOISE  = 2'd1;
  localparam logic [1:0] ST_SKIP   = 2'd2;
  localparam logic [1:0] ST_TICK   = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TimeW-1:0] time_us;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            synced;
    logic            running;
    logic [RegW-1:0] tooth_index;
    logic [RegW-1:0] cycle_count;
  } out_word_t;

  // saturating increment of a 16-bit counter
  function automatic logic [RegW-1:0] sat_inc(input logic [RegW-1:0] v);
    sat_inc = (v == {RegW{1'b1}}) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

/* rtl/crank_sync_trigger_decoder_core.sv */
// crank/sync trigger decoder core, uses cstd_pkg; one result word per input word
// each word passes the input register, then the result register; a stalled result holds it in between
// throughput: one word per cycle while the result is not stalled; the decode is two 32-bit gap subtracts and compares
// an input register and the result register let a new word in while a result waits
// reset: asynchronous active low; config returns to defaults, timers/counters/flags clear
// config writes are always ready; writes to unused indexes are dropped
`default_nettype none

module crank_sync_trigger_decoder_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // event words
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  cstd_pkg::in_word_t           in_word_i,
  // result words
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output cstd_pkg::out_word_t          out_word_o,
  // config writes
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [cstd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [cstd_pkg::RegW-1:0]     cfg_data_i
);
  import cstd_pkg::*;

  // ---------------------------------------------------------------------------
  // handshake: input register feeds the result register
  // ---------------------------------------------------------------------------
  logic     in_valid_q;
  in_word_t in_word_q;
  logic     out_valid_q;
  out_word_t out_word_q, out_word_d;

  logic out_free;   // result register can take a new word this cycle
  logic advance;    // word in the input register is decoded this cycle

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [RegW-1:0] crank_filter_q, sync_filter_q, cranking_cyc_q;
  logic [RegW-1:0] sync_timeout_q, crank_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crank_filter_q  <= CRANK_FILTER_RST;
      sync_filter_q   <= SYNC_FILTER_RST;
      cranking_cyc_q  <= CRANKING_CYC_RST;
      sync_timeout_q  <= SYNC_TIMEOUT_RST;
      crank_timeout_q <= CRANK_TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CRANK_FILTER:  crank_filter_q  <= cfg_data_i;
        CFG_SYNC_FILTER:   sync_filter_q   <= cfg_data_i;
        CFG_CRANKING_CYC:  cranking_cyc_q  <= cfg_data_i;
        CFG_SYNC_TIMEOUT:  sync_timeout_q  <= cfg_data_i;
        CFG_CRANK_TIMEOUT: crank_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // decoder state
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0] last_crank_q, last_crank_d;
  logic [TimeW-1:0] last_sync_q, last_sync_d;
  logic             sync_seen_q, sync_seen_d;
  logic             running_q, running_d;
  logic [RegW-1:0]  tooth_q, tooth_d;
  logic [RegW-1:0]  cycles_q, cycles_d;
  logic [RegW-1:0]  crank_idle_q, crank_idle_d;
  logic [RegW-1:0]  sync_idle_q, sync_idle_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_crank_q <= '0;
      last_sync_q  <= '0;
      sync_seen_q  <= 1'b0;
      running_q    <= 1'b0;
      tooth_q      <= '0;
      cycles_q     <= '0;
      crank_idle_q <= '0;
      sync_idle_q  <= '0;
    end else if (advance) begin
      last_crank_q <= last_crank_d;
      last_sync_q  <= last_sync_d;
      sync_seen_q  <= sync_seen_d;
      running_q    <= running_d;
      tooth_q      <= tooth_d;
      cycles_q     <= cycles_d;
      crank_idle_q <= crank_idle_d;
      sync_idle_q  <= sync_idle_d;
    end
  end

  // ---------------------------------------------------------------------------
  // event decode
  // ---------------------------------------------------------------------------
  // both gaps wrap modulo 2^32; an edge at or inside the filter window is noise
  logic [TimeW-1:0] crank_gap, sync_gap;
  logic             crank_noise, sync_noise;
  logic [RegW-1:0]  cycles_inc, crank_idle_inc, sync_idle_inc;
  logic [1:0]       status;

  assign crank_gap   = in_word_q.time_us - last_crank_q;
  assign sync_gap    = in_word_q.time_us - last_sync_q;
  assign crank_noise = crank_gap <= {{(TimeW-RegW){1'b0}}, crank_filter_q};
  assign sync_noise  = sync_gap  <= {{(TimeW-RegW){1'b0}}, sync_filter_q};

  // an unsynced crank edge restarts the cycle count
  assign cycles_inc     = sync_seen_q ? sat_inc(cycles_q) : '0;
  assign crank_idle_inc = sat_inc(crank_idle_q);
  assign sync_idle_inc  = sat_inc(sync_idle_q);

  always_comb begin
    last_crank_d = last_crank_q;
    last_sync_d  = last_sync_q;
    sync_seen_d  = sync_seen_q;
    running_d    = running_q;
    tooth_d      = tooth_q;
    cycles_d     = cycles_q;
    crank_idle_d = crank_idle_q;
    sync_idle_d  = sync_idle_q;
    status       = ST_NOISE;

    case (in_word_q.req_type)
      REQ_CRANK: begin
        last_crank_d = in_word_q.time_us;
        if (!crank_noise) begin
          status       = ST_ACCEPT;
          crank_idle_d = '0;
          cycles_d     = cycles_inc;
          tooth_d      = sat_inc(tooth_q);
          if (cycles_inc > cranking_cyc_q) begin
            running_d = 1'b1;
          end
        end
      end
      REQ_SYNC: begin
        last_sync_d = in_word_q.time_us;
        if (!sync_noise) begin
          // a sync at the second tooth is the other cam lobe: skip it
          if (tooth_q == SKIP_TOOTH) begin
            status = ST_SKIP;
          end else begin
            status      = ST_ACCEPT;
            sync_idle_d = '0;
            sync_seen_d = 1'b1;
            tooth_d     = '0;
          end
        end
      end
      REQ_TICK: begin
        // advance idle timers first, then check timeouts on the new values
        status       = ST_TICK;
        crank_idle_d = crank_idle_inc;
        sync_idle_d  = sync_idle_inc;
        if (sync_idle_inc > sync_timeout_q) begin
          sync_seen_d = 1'b0;
        end
        if (crank_idle_inc > crank_timeout_q) begin
          running_d = 1'b0;
          tooth_d   = '0;
          cycles_d  = '0;
        end
      end
      default: begin
        // unused request code: state untouched, reported as noise
        status = ST_NOISE;
      end
    endcase

    out_word_d.status      = status;
    out_word_d.synced      = sync_seen_d;
    out_word_d.running     = running_d;
    out_word_d.tooth_index = tooth_d;
    out_word_d.cycle_count = cycles_d;
  end

`ifndef SYNTHESIS
  // input side only blocks while both registers are full and the result is stalled
  a_ready_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // a skipped sync leaves the tooth index at the skip tooth
  a_skip_tooth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == ST_SKIP) |-> (out_word_o.tooth_index == SKIP_TOOTH))
    else $error("sync skip reported with wrong tooth index");

  // decoder state moves only when a word is decoded
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(tooth_q) && $stable(cycles_q) && $stable(last_crank_q)))
    else $error("decoder state changed without a decoded word");

  // a crank filter write lands in the register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == CFG_CRANK_FILTER) |=> (crank_filter_q == $past(cfg_data_i)))
    else $error("crank filter write lost");
`endif

endmodule

`default_nettype wire
